>>> rtl/urh_pkg.sv
// Shared constants, operation codes and control types for the undo/redo history ring.
package urh_pkg;

	localparam int DEPTH_DEF       = 16;
	localparam int ENTRY_WIDTH_DEF = 64;
	localparam int MODE_W          = 3;
	localparam int WORD_W          = 64;

	localparam logic [MODE_W-1:0] MODE_PUSH  = 3'd0;
	localparam logic [MODE_W-1:0] MODE_UNDO  = 3'd1;
	localparam logic [MODE_W-1:0] MODE_REDO  = 3'd2;
	localparam logic [MODE_W-1:0] MODE_READ  = 3'd3;
	localparam logic [MODE_W-1:0] MODE_CLEAR = 3'd4;

	typedef struct packed {
		logic capture;
		logic execute;
	} urh_cmd_t;

endpackage

>>> rtl/undo_redo_history_ring.sv
// Top level of the undo/redo history ring.
// The ring holds DEPTH snapshot words and answers one result beat for every input beat:
// push, undo, redo, read current or clear. Each beat goes through capture, execute
// (at most one access to the snapshot memory) and the result held until taken,
// and the next input beat is taken once the previous result has left. Only the low
// ENTRY_WIDTH bits of a pushed word are kept; entry_out is zero-extended. The memory
// needs no clearing after reset, since only pushed entries are ever read.
module undo_redo_history_ring #(
	parameter int DEPTH       = urh_pkg::DEPTH_DEF,
	parameter int ENTRY_WIDTH = urh_pkg::ENTRY_WIDTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [urh_pkg::MODE_W-1:0] mode,
	input  logic [urh_pkg::WORD_W-1:0] entry_in,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic                       ok,
	output logic [urh_pkg::WORD_W-1:0] entry_out,
	output logic [$clog2(DEPTH+1)-1:0] valid_count,
	output logic [$clog2(DEPTH)-1:0]   cursor_pos
);
	import urh_pkg::*;

	urh_cmd_t cmd;

	urh_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	urh_dp #(
		.DEPTH       (DEPTH),
		.ENTRY_WIDTH (ENTRY_WIDTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.mode        (mode),
		.entry_in    (entry_in),
		.ok          (ok),
		.entry_out   (entry_out),
		.valid_count (valid_count),
		.cursor_pos  (cursor_pos)
	);

endmodule

>>> rtl/urh_ctrl.sv
// Controller state machine that sequences capture, execution and result delivery.
module urh_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	output urh_pkg::urh_cmd_t cmd
);
	import urh_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_EXEC = 2'd1;
	localparam logic [1:0] ST_RESP = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_next;

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_next = ST_EXEC;
				end
			end
			ST_EXEC: begin
				state_next = ST_RESP;
			end
			ST_RESP: begin
				if (!out_stall) begin
					state_next = ST_IDLE;
				end
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	assign in_stall    = (state_q != ST_IDLE);
	assign out_valid   = (state_q == ST_RESP);
	assign cmd.capture = in_valid && (state_q == ST_IDLE);
	assign cmd.execute = (state_q == ST_EXEC);

endmodule

>>> rtl/urh_dp.sv
// Datapath with the snapshot memory, the ring pointers and the result registers.
module urh_dp #(
	parameter int DEPTH       = urh_pkg::DEPTH_DEF,
	parameter int ENTRY_WIDTH = urh_pkg::ENTRY_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  urh_pkg::urh_cmd_t            cmd,
	input  logic [urh_pkg::MODE_W-1:0]   mode,
	input  logic [urh_pkg::WORD_W-1:0]   entry_in,
	output logic                         ok,
	output logic [urh_pkg::WORD_W-1:0]   entry_out,
	output logic [$clog2(DEPTH+1)-1:0]   valid_count,
	output logic [$clog2(DEPTH)-1:0]     cursor_pos
);
	import urh_pkg::*;

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int SW = PW + 1;
	localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);
	localparam logic [SW-1:0] DEPTH_S   = SW'(DEPTH);
	localparam logic [CW-1:0] DEPTH_C   = CW'(DEPTH);

	logic [ENTRY_WIDTH-1:0] mem_q [DEPTH];
	logic [ENTRY_WIDTH-1:0] rd_data_q;
	logic [ENTRY_WIDTH-1:0] word_q;
	logic [MODE_W-1:0]      mode_q;

	logic [PW-1:0] newest_q;
	logic [PW-1:0] cursor_q;
	logic [CW-1:0] count_q;
	logic          ok_q;
	logic          data_q;

	logic [PW-1:0] cursor_next;
	logic [PW-1:0] cursor_prev;
	logic [SW-1:0] oldest_sum;
	logic [PW-1:0] oldest;
	logic [SW-1:0] cut_sum;
	logic [PW-1:0] cut_idx;
	logic [CW-1:0] base_count;
	logic          empty;
	logic          at_newest;

	logic [PW-1:0] newest_d;
	logic [PW-1:0] cursor_d;
	logic [CW-1:0] count_d;
	logic          ok_d;
	logic          rd_en;
	logic [PW-1:0] rd_addr;
	logic          wr_en;
	logic [PW-1:0] wr_addr;

	always_comb begin
		cursor_next = (cursor_q == LAST_SLOT) ? '0 : cursor_q + PW'(1);
		cursor_prev = (cursor_q == '0) ? LAST_SLOT : cursor_q - PW'(1);
		oldest_sum  = SW'(newest_q) + DEPTH_S - (SW'(count_q) - SW'(1));
		oldest      = (oldest_sum >= DEPTH_S) ? PW'(oldest_sum - DEPTH_S) : PW'(oldest_sum);
		cut_sum     = SW'(cursor_q) + DEPTH_S - SW'(oldest);
		cut_idx     = (cut_sum >= DEPTH_S) ? PW'(cut_sum - DEPTH_S) : PW'(cut_sum);
		empty       = (count_q == '0);
		at_newest   = (cursor_q == newest_q);
		base_count  = at_newest ? count_q : CW'(cut_idx) + CW'(1);
	end

	always_comb begin
		newest_d = newest_q;
		cursor_d = cursor_q;
		count_d  = count_q;
		ok_d     = 1'b0;
		rd_en    = 1'b0;
		rd_addr  = cursor_q;
		wr_en    = 1'b0;
		wr_addr  = cursor_next;
		unique case (mode_q)
			MODE_PUSH: begin
				ok_d  = 1'b1;
				wr_en = 1'b1;
				if (empty) begin
					newest_d = '0;
					cursor_d = '0;
					count_d  = CW'(1);
					wr_addr  = '0;
				end else begin
					newest_d = cursor_next;
					cursor_d = cursor_next;
					count_d  = (base_count < DEPTH_C) ? base_count + CW'(1) : base_count;
				end
			end
			MODE_UNDO: begin
				if (!empty && (cursor_q != oldest)) begin
					ok_d     = 1'b1;
					cursor_d = cursor_prev;
					rd_en    = 1'b1;
					rd_addr  = cursor_prev;
				end
			end
			MODE_REDO: begin
				if (!empty && !at_newest) begin
					ok_d     = 1'b1;
					cursor_d = cursor_next;
					rd_en    = 1'b1;
					rd_addr  = cursor_next;
				end
			end
			MODE_READ: begin
				if (!empty) begin
					ok_d  = 1'b1;
					rd_en = 1'b1;
				end
			end
			MODE_CLEAR: begin
				ok_d     = 1'b1;
				newest_d = '0;
				cursor_d = '0;
				count_d  = '0;
			end
			default: begin
				ok_d = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			mode_q <= mode;
			word_q <= entry_in[ENTRY_WIDTH-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.execute && wr_en) begin
			mem_q[wr_addr] <= word_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.execute && rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			newest_q <= '0;
			cursor_q <= '0;
			count_q  <= '0;
			ok_q     <= 1'b0;
			data_q   <= 1'b0;
		end else if (cmd.execute) begin
			newest_q <= newest_d;
			cursor_q <= cursor_d;
			count_q  <= count_d;
			ok_q     <= ok_d;
			data_q   <= rd_en;
		end
	end

	assign ok          = ok_q;
	assign entry_out   = data_q ? WORD_W'(rd_data_q) : '0;
	assign valid_count = count_q;
	assign cursor_pos  = cursor_q;

endmodule
